// File: rtl/go_back_n_sender_assert.svh
// Assertion macros shared by the go-back-n sender RTL.
`ifndef GO_BACK_N_SENDER_ASSERT_SVH
`define GO_BACK_N_SENDER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define GBN_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define GBN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define GBN_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define GBN_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/gbn_pkg.sv
// Types, constants and the slot lookup table of the go-back-n sender.
package gbn_pkg;

   localparam int WIN_SLOTS     = 4;
   localparam int SEQ_BITS      = 3;
   localparam int PAYLOAD_WIDTH = 32;

   localparam int SEQ_COUNT = 1 << SEQ_BITS;
   localparam int TID_BITS  = SEQ_BITS + 1;
   localparam int SLOT_BITS = (WIN_SLOTS > 1) ? $clog2(WIN_SLOTS) : 1;
   localparam int WIN_BITS  = $clog2(WIN_SLOTS + 1);
   localparam int CNT_BITS  = (SEQ_BITS > WIN_BITS) ? SEQ_BITS : WIN_BITS;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_SEND    = 2'd0;
   localparam cmd_type CMD_ACK     = 2'd1;
   localparam cmd_type CMD_TIMEOUT = 2'd2;

   typedef enum logic [0:0] {
      GBN_IDLE,
      GBN_REPLAY
   } gbn_state_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [PAYLOAD_WIDTH-1:0] payload;
      logic [SEQ_BITS-1:0]      ack_number;
      logic                     ack_intact;
      logic [SEQ_BITS-1:0]      expired_timer;
   } req_type;

   typedef struct packed {
      logic                       accepted;
      logic                       pkt_valid;
      logic [SEQ_BITS-1:0]        pkt_seq;
      logic [PAYLOAD_WIDTH-1:0]   pkt_data;
      logic                       stop_timer;
      logic signed [TID_BITS-1:0] stop_timer_id;
      logic                       start_timer;
      logic [SEQ_BITS-1:0]        start_timer_id;
      logic                       last;
   } rsp_type;

   typedef logic [SLOT_BITS-1:0] slot_lut_type [SEQ_COUNT];

   // Maps a sequence number onto its storage slot (sequence modulo window).
   function automatic slot_lut_type build_slot_lut();
      slot_lut_type lut;
      for (int i = 0; i < SEQ_COUNT; i++) begin
         lut[i] = SLOT_BITS'(i % WIN_SLOTS);
      end
      return lut;
   endfunction

   localparam slot_lut_type SLOT_LUT = build_slot_lut();

endpackage

// File: rtl/go_back_n_sender.sv
// Go-Back-N sender: window bookkeeping, payload slots and the timeout replay sequencer.
//
// A request is taken when start is high and busy is low. Send and acknowledgement
// requests give a single result on the rsp_ ports in the following cycle, marked by
// rsp_valid; busy stays low, so the next request may follow at once. A corrupt
// acknowledgement or an unused command produces no result. A timeout replays every
// outstanding packet, oldest first and at most a window's worth, one packet per cycle
// through the shared sequence adder: busy is high while the replay runs and results
// appear on consecutive cycles, the last of them carrying the timer requests. With
// nothing outstanding a timeout gives a single result with only the timer requests in
// the following cycle, and busy stays low. The receiver cannot stall, so each result
// is valid for exactly one cycle and must be taken then.
`include "go_back_n_sender_assert.svh"

module go_back_n_sender
   import gbn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   gbn_state_type state_ff, state_in;

   logic [SEQ_BITS-1:0]        base_ff, base_in;
   logic [SEQ_BITS-1:0]        next_ff, next_in;
   logic signed [TID_BITS-1:0] timer_ff, timer_in;
   logic [CNT_BITS-1:0]        idx_ff, idx_in;
   logic [CNT_BITS-1:0]        count_ff, count_in;
   logic [SEQ_BITS-1:0]        expired_ff, expired_in;
   logic [PAYLOAD_WIDTH-1:0]   slot_ff [WIN_SLOTS];
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   logic                       accept;
   logic                       slot_we;
   logic [SEQ_BITS-1:0]        add_a, add_b, add_sum;
   logic                       add_cin;
   logic [CNT_BITS-1:0]        gap;
   logic [CNT_BITS-1:0]        count;
   logic                       replay_fin;
   logic [SEQ_BITS-1:0]        ack_base;

   assign accept = start & ~busy;

   // Shared adder: the window gap while idle, the replayed sequence number otherwise.
   always_comb begin
      if (state_ff == GBN_REPLAY) begin
         add_a   = base_ff;
         add_b   = idx_ff[SEQ_BITS-1:0];
         add_cin = 1'b0;
      end else begin
         add_a   = next_ff;
         add_b   = ~base_ff;
         add_cin = 1'b1;
      end
      add_sum = add_a + add_b + SEQ_BITS'(add_cin);
   end

   assign gap        = CNT_BITS'(add_sum);
   assign count      = (gap >= CNT_BITS'(WIN_SLOTS)) ? CNT_BITS'(WIN_SLOTS) : gap;
   assign replay_fin = ((idx_ff + CNT_BITS'(1)) == count_ff);
   assign ack_base   = req_item.ack_number + SEQ_BITS'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         GBN_IDLE: begin
            if (accept && req_item.cmd == CMD_TIMEOUT && count != '0) begin
               state_in = GBN_REPLAY;
            end
         end
         GBN_REPLAY: begin
            if (replay_fin) begin
               state_in = GBN_IDLE;
            end
         end
         default: state_in = GBN_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      base_in      = base_ff;
      next_in      = next_ff;
      timer_in     = timer_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      expired_in   = expired_ff;
      slot_we      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      busy         = (state_ff == GBN_REPLAY);

      case (state_ff)
         GBN_IDLE: begin
            if (accept) begin
               case (req_item.cmd)
                  CMD_SEND: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.last  = 1'b1;
                     if (gap < CNT_BITS'(WIN_SLOTS)) begin
                        slot_we           = 1'b1;
                        rsp_in.accepted   = 1'b1;
                        rsp_in.pkt_valid  = 1'b1;
                        rsp_in.pkt_seq    = next_ff;
                        rsp_in.pkt_data   = req_item.payload;
                        next_in           = next_ff + SEQ_BITS'(1);
                        if (base_ff == next_ff) begin
                           rsp_in.start_timer    = 1'b1;
                           rsp_in.start_timer_id = base_ff;
                           timer_in              = $signed(TID_BITS'(base_ff));
                        end
                     end
                  end
                  CMD_ACK: begin
                     if (req_item.ack_intact) begin
                        base_in              = ack_base;
                        rsp_valid_in         = 1'b1;
                        rsp_in.last          = 1'b1;
                        rsp_in.stop_timer    = 1'b1;
                        rsp_in.stop_timer_id = timer_ff;
                        if (ack_base != next_ff) begin
                           rsp_in.start_timer    = 1'b1;
                           rsp_in.start_timer_id = ack_base;
                           timer_in              = $signed(TID_BITS'(ack_base));
                        end
                     end
                  end
                  CMD_TIMEOUT: begin
                     timer_in   = $signed(TID_BITS'(base_ff));
                     expired_in = req_item.expired_timer;
                     count_in   = count;
                     idx_in     = '0;
                     if (count == '0) begin
                        rsp_valid_in          = 1'b1;
                        rsp_in.last           = 1'b1;
                        rsp_in.stop_timer     = 1'b1;
                        rsp_in.stop_timer_id  = $signed(TID_BITS'(req_item.expired_timer));
                        rsp_in.start_timer    = 1'b1;
                        rsp_in.start_timer_id = base_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         GBN_REPLAY: begin
            rsp_valid_in     = 1'b1;
            rsp_in.pkt_valid = 1'b1;
            rsp_in.pkt_seq   = add_sum;
            rsp_in.pkt_data  = slot_ff[SLOT_LUT[add_sum]];
            idx_in           = idx_ff + CNT_BITS'(1);
            if (replay_fin) begin
               idx_in                = '0;
               rsp_in.last           = 1'b1;
               rsp_in.stop_timer     = 1'b1;
               rsp_in.stop_timer_id  = $signed(TID_BITS'(expired_ff));
               rsp_in.start_timer    = 1'b1;
               rsp_in.start_timer_id = base_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= GBN_IDLE;
         base_ff      <= '0;
         next_ff      <= '0;
         timer_ff     <= '1;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         timer_ff     <= timer_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      expired_ff <= expired_in;
      rsp_ff     <= rsp_in;
      if (slot_we) begin
         slot_ff[SLOT_LUT[next_ff]] <= req_item.payload;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `GBN_ASSERT_IMPL(a_nonlast_only_in_replay, clock, reset,
      rsp_valid && !rsp_item.last, busy, "non-final result outside a replay")
   `GBN_ASSERT_IMPL(a_bare_result_is_last, clock, reset,
      rsp_valid && !rsp_item.pkt_valid, rsp_item.last, "result without a packet is not final")
   `GBN_ASSERT_IMPL(a_replay_index_bound, clock, reset,
      state_ff == GBN_REPLAY, idx_ff < count_ff, "replay index has passed its count")
   `GBN_ASSERT_NEXT(a_replay_emits, clock, reset,
      state_ff == GBN_REPLAY, rsp_valid && rsp_item.pkt_valid, "replay cycle produced no packet")

endmodule
